[hdl/pedestrian_traffic_light_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the pedestrian traffic light controller
// ----------------------------------------------------------------------------
`ifndef PEDESTRIAN_TRAFFIC_LIGHT_CONTROLLER_CORE_MACROS_SVH
`define PEDESTRIAN_TRAFFIC_LIGHT_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PTLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptlc: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PTLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptlc: next-cycle check failed");

`endif

[hdl/ptlc_pkg.sv]
// ----------------------------------------------------------------------------
// ptlc_pkg
// types, codes and the mode logic shared by the controller modules
// ----------------------------------------------------------------------------
`default_nettype none

package ptlc_pkg;

	// configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_PRESS_LIMIT = '0;
	localparam logic [7:0] SHORT_PRESS_LIMIT_RST = 8'd3;

	// request kinds
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_BUTTON = 1'b1;

	// recorded car phase codes
	localparam logic [1:0] PH_GREEN  = 2'd0;
	localparam logic [1:0] PH_YELLOW = 2'd1;
	localparam logic [1:0] PH_RED    = 2'd2;

	// second marks
	localparam logic [4:0] SEC_GREEN_END   = 5'd5;
	localparam logic [4:0] SEC_BLINK1_END  = 5'd10;
	localparam logic [4:0] SEC_RED_END     = 5'd15;
	localparam logic [4:0] SEC_BLINK2_END  = 5'd20;
	localparam logic [4:0] SEC_HOLD_END    = 5'd2;
	localparam logic [4:0] SEC_PHASE_END   = 5'd5;
	localparam logic [4:0] SEC_CROSS_END   = 5'd10;
	localparam logic [5:0] CYCLE_NORMAL    = 6'd20;
	localparam logic [5:0] CYCLE_CROSS     = 6'd25;

	typedef struct packed {
		logic req_type;
		logic button_level;
	} req_word_t;

	typedef struct packed {
		logic walk_green;
		logic walk_yellow;
		logic walk_red;
		logic car_green;
		logic car_yellow;
		logic car_red;
	} lamps_t;

	typedef struct packed {
		logic       mode;
		logic [4:0] seconds;
		logic [1:0] phase;
		lamps_t     lamps;
	} ctrl_state_t;

	typedef struct packed {
		logic        moved;
		ctrl_state_t st;
	} pass_t;

	// one pass of the mode logic; moved is set when a crossing pass changed phase or left crossing mode
	function automatic pass_t mode_pass(input ctrl_state_t s);
		pass_t r;
		logic  odd;
		r.moved = 1'b0;
		r.st    = s;
		odd     = s.seconds[0];
		if (!s.mode) begin
			if (s.seconds < SEC_GREEN_END) begin
				r.st.lamps.car_green  = 1'b1;
				r.st.lamps.car_yellow = 1'b0;
				r.st.lamps.car_red    = 1'b0;
				r.st.phase            = PH_GREEN;
			end else if (s.seconds < SEC_BLINK1_END || (s.seconds >= SEC_RED_END &&
					s.seconds < SEC_BLINK2_END)) begin
				r.st.lamps.car_green  = 1'b0;
				r.st.lamps.car_red    = 1'b0;
				r.st.lamps.car_yellow = odd;
				r.st.phase            = PH_YELLOW;
			end else if (s.seconds < SEC_RED_END) begin
				r.st.lamps.car_yellow = 1'b0;
				r.st.lamps.car_green  = 1'b0;
				r.st.lamps.car_red    = 1'b1;
				r.st.phase            = PH_RED;
			end
		end else begin
			case (s.phase)
				PH_RED: begin
					r.st.lamps.car_yellow  = 1'b0;
					r.st.lamps.walk_yellow = 1'b0;
					if (s.seconds < SEC_PHASE_END) begin
						r.st.lamps.walk_green = 1'b1;
						r.st.lamps.car_red    = 1'b1;
					end else if (s.seconds < SEC_CROSS_END) begin
						r.st.lamps.walk_green  = 1'b0;
						r.st.lamps.car_red     = 1'b0;
						r.st.lamps.car_yellow  = odd;
						r.st.lamps.walk_yellow = odd;
					end else begin
						r.st.mode    = 1'b0;
						r.st.seconds = '0;
						r.st.lamps   = '0;
						r.moved      = 1'b1;
					end
				end
				PH_YELLOW: begin
					r.st.lamps.walk_red  = 1'b0;
					r.st.lamps.car_green = 1'b0;
					if (s.seconds < SEC_PHASE_END) begin
						r.st.lamps.car_yellow  = odd;
						r.st.lamps.walk_yellow = odd;
					end else begin
						r.st.seconds = '0;
						r.st.phase   = PH_RED;
						r.moved      = 1'b1;
					end
				end
				PH_GREEN: begin
					r.st.lamps.car_green = 1'b1;
					if (s.seconds < SEC_HOLD_END) begin
						r.st.lamps.walk_red = 1'b1;
					end else begin
						r.st.seconds = '0;
						r.st.phase   = PH_YELLOW;
						r.moved      = 1'b1;
					end
				end
				default: ;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/ptlc_if.sv]
// ----------------------------------------------------------------------------
// ptlc channel interfaces
// request channel (ticks and button changes) and result channel (lamps)
// ----------------------------------------------------------------------------
`default_nettype none

interface ptlc_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic button_level;

	modport source (output valid, output req_type, output button_level, input ready);
	modport sink (input valid, input req_type, input button_level, output ready);
endinterface

interface ptlc_res_if;
	logic       valid;
	logic       ready;
	logic       car_red;
	logic       car_yellow;
	logic       car_green;
	logic       walk_red;
	logic       walk_yellow;
	logic       walk_green;
	logic       crossing_mode;
	logic [1:0] car_phase;
	logic [4:0] second_count;

	modport source (output valid, output car_red, output car_yellow, output car_green,
		output walk_red, output walk_yellow, output walk_green, output crossing_mode,
		output car_phase, output second_count, input ready);
	modport sink (input valid, input car_red, input car_yellow, input car_green,
		input walk_red, input walk_yellow, input walk_green, input crossing_mode,
		input car_phase, input second_count, output ready);
endinterface

`default_nettype wire

[hdl/pedestrian_traffic_light_controller_core.sv]
// Request words (one-second tick or button level change) can be taken on every clock
// cycle, and each gives exactly one result word with the six lamps, mode, phase and
// second count. An accepted word is held in the input register. From there the
// control stage applies it, settles the mode logic in two chained passes and
// loads the result register, which drives the result channel. One word per cycle
// is sustained while the result side takes every word, because the input ready
// follows the result ready in the same cycle. A stalled result holds the next word
// in the input register, and once that register is full, ready stays low until
// the result is taken.
// The short press limit sits at byte address 0 of the APB port.
`default_nettype none

// ----------------------------------------------------------------------------
// pedestrian_traffic_light_controller_core
// traffic light controller with pedestrian request button
// ----------------------------------------------------------------------------
module pedestrian_traffic_light_controller_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ptlc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ptlc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ptlc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	ptlc_req_if.sink                         req,
	ptlc_res_if.source                       res
);
	import ptlc_pkg::*;

	logic [7:0] limit;
	logic       take;
	logic       valid_s1;
	req_word_t  word_s1;

	// configuration registers
	ptlc_cfg u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.short_press_limit (limit)
	);

	// input register
	ptlc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	// control stage
	ptlc_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_s1          (valid_s1),
		.word_s1           (word_s1),
		.short_press_limit (limit),
		.take              (take),
		.res               (res)
	);

endmodule

`default_nettype wire

[hdl/ptlc_cfg.sv]
// ----------------------------------------------------------------------------
// ptlc_cfg
// APB register file holding the short press limit
// ----------------------------------------------------------------------------
`default_nettype none

module ptlc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ptlc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ptlc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ptlc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic [7:0]                       short_press_limit
);
	import ptlc_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [7:0]           limit_q;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SHORT_PRESS_LIMIT_RST;
		end else if (wr_en && reg_idx == REG_SHORT_PRESS_LIMIT) begin
			limit_q <= pwdata[7:0];
		end
	end

	// read decode
	always_comb begin
		unique case (reg_idx)
			REG_SHORT_PRESS_LIMIT: prdata = {{(APB_DATA_W-8){1'b0}}, limit_q};
			default:               prdata = '0;
		endcase
	end

	assign short_press_limit = limit_q;

endmodule

`default_nettype wire

[hdl/ptlc_in_stage.sv]
// ----------------------------------------------------------------------------
// ptlc_in_stage
// input register for request words
// ----------------------------------------------------------------------------
`default_nettype none

module ptlc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	ptlc_req_if.sink            req,
	input  logic                take,
	output logic                valid_s1,
	output ptlc_pkg::req_word_t word_s1
);
	import ptlc_pkg::*;

	logic acc;

	// free when empty or when the held word moves on this cycle
	assign req.ready = !valid_s1 || take;
	assign acc       = req.valid && req.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// word capture
	always_ff @(posedge clk) begin
		if (acc) begin
			word_s1.req_type     <= req.req_type;
			word_s1.button_level <= req.button_level;
		end
	end

endmodule

`default_nettype wire

[hdl/ptlc_ctrl.sv]
// ----------------------------------------------------------------------------
// ptlc_ctrl
// controller state, next-state logic and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ptlc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  ptlc_pkg::req_word_t word_s1,
	input  logic [7:0]          short_press_limit,
	output logic                take,
	ptlc_res_if.source          res
);
	import ptlc_pkg::*;

	ctrl_state_t st_q;
	logic [7:0]  press_q;
	logic        res_valid_q;

	ctrl_state_t st_in;
	logic [7:0]  press_nxt;
	logic [5:0]  sec_inc;
	logic [5:0]  cycle_len;
	pass_t       pass1;
	pass_t       pass2;
	ctrl_state_t st_nxt;

	assign take = valid_s1 && (!res_valid_q || res.ready);

	// apply the request word
	always_comb begin
		st_in     = st_q;
		press_nxt = press_q;
		sec_inc   = {1'b0, st_q.seconds} + 6'd1;
		cycle_len = st_q.mode ? CYCLE_CROSS : CYCLE_NORMAL;
		if (word_s1.req_type == REQ_TICK) begin
			if (sec_inc >= cycle_len) begin
				st_in.seconds = 5'(sec_inc - cycle_len);
			end else begin
				st_in.seconds = sec_inc[4:0];
			end
			press_nxt = press_q + 8'd1;
		end else if (!st_q.mode) begin
			if (word_s1.button_level) begin
				press_nxt = '0;
			end else if (press_q < short_press_limit) begin
				st_in.mode    = 1'b1;
				st_in.seconds = '0;
				st_in.lamps   = '0;
			end
		end
	end

	// mode logic settles within two passes: a phase change is always followed by a resting pass
	assign pass1  = mode_pass(st_in);
	assign pass2  = mode_pass(pass1.st);
	assign st_nxt = pass1.moved ? pass2.st : pass1.st;

	// state doubles as result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode    <= 1'b0;
			st_q.seconds <= '0;
			st_q.phase   <= PH_GREEN;
			st_q.lamps   <= '0;
			press_q      <= '0;
			res_valid_q  <= 1'b0;
		end else if (take) begin
			st_q        <= st_nxt;
			press_q     <= press_nxt;
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result word
	assign res.valid         = res_valid_q;
	assign res.car_red       = st_q.lamps.car_red;
	assign res.car_yellow    = st_q.lamps.car_yellow;
	assign res.car_green     = st_q.lamps.car_green;
	assign res.walk_red      = st_q.lamps.walk_red;
	assign res.walk_yellow   = st_q.lamps.walk_yellow;
	assign res.walk_green    = st_q.lamps.walk_green;
	assign res.crossing_mode = st_q.mode;
	assign res.car_phase     = st_q.phase;
	assign res.second_count  = st_q.seconds;

endmodule

`default_nettype wire

[hdl/ptlc_checker.sv]
// ----------------------------------------------------------------------------
// ptlc_checker
// port-level checks on the result channel of the controller
// ----------------------------------------------------------------------------
`default_nettype none

`include "pedestrian_traffic_light_controller_core_macros.svh"

module ptlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       car_red,
	input logic       car_yellow,
	input logic       car_green,
	input logic       walk_red,
	input logic       walk_yellow,
	input logic       walk_green,
	input logic       crossing_mode,
	input logic [1:0] car_phase,
	input logic [4:0] second_count
);
	import ptlc_pkg::*;

	logic [14:0] res_word;
	logic        stalled;
	logic        normal_out;
	logic        cross_out;
	logic        normal_ok;

	assign res_word   = {car_red, car_yellow, car_green, walk_red, walk_yellow, walk_green,
		crossing_mode, car_phase, second_count, 1'b0};
	assign stalled    = res_valid && !res_ready;
	assign normal_out = res_valid && !crossing_mode;
	assign cross_out  = res_valid && crossing_mode;
	assign normal_ok  = second_count < SEC_BLINK2_END && car_phase <= PH_RED;

	// a stalled result word holds
	`PTLC_ASSERT_NXT(a_res_hold, clk, arst_n, stalled, res_valid && $stable(res_word))

	// normal cycle stays within its twenty seconds and a defined phase
	`PTLC_ASSERT_IMP(a_normal_range, clk, arst_n, normal_out, normal_ok)

	// pedestrian lamps are dark in the normal cycle
	`PTLC_ASSERT_IMP(a_normal_walk_dark, clk, arst_n, normal_out, !walk_red && !walk_yellow && !walk_green)

	// a settled crossing never shows ten seconds or more
	`PTLC_ASSERT_IMP(a_cross_range, clk, arst_n, cross_out, second_count < SEC_CROSS_END)

endmodule

bind pedestrian_traffic_light_controller_core ptlc_checker u_ptlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.car_red       (res.car_red),
	.car_yellow    (res.car_yellow),
	.car_green     (res.car_green),
	.walk_red      (res.walk_red),
	.walk_yellow   (res.walk_yellow),
	.walk_green    (res.walk_green),
	.crossing_mode (res.crossing_mode),
	.car_phase     (res.car_phase),
	.second_count  (res.second_count)
);

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives tick and button words into the pedestrian traffic light controller,
// predicts every result word in step and compares it field by field, across
// several short press limits and with both sides stalling at random
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import ptlc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SEGMENTS    = 6;
	localparam int unsigned SEG_WORDS   = 90;
	localparam logic        LEVEL_UP    = 1'b0;
	localparam logic        LEVEL_DOWN  = 1'b1;

	// lamp bits of the predicted lamp register
	localparam logic [5:0] LAMP_CAR_RED    = 6'h01;
	localparam logic [5:0] LAMP_CAR_YELLOW = 6'h02;
	localparam logic [5:0] LAMP_CAR_GREEN  = 6'h04;
	localparam logic [5:0] LAMP_WALK_RED   = 6'h08;
	localparam logic [5:0] LAMP_WALK_YEL   = 6'h10;
	localparam logic [5:0] LAMP_WALK_GREEN = 6'h20;

	typedef struct packed {
		logic       car_red;
		logic       car_yellow;
		logic       car_green;
		logic       walk_red;
		logic       walk_yellow;
		logic       walk_green;
		logic       crossing_mode;
		logic [1:0] car_phase;
		logic [4:0] second_count;
	} lamp_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ptlc_req_if req_ch ();
	ptlc_res_if res_ch ();

	pedestrian_traffic_light_controller_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.res     (res_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	req_word_t    pending_words[$];
	lamp_result_t expected_lamps[$];
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	int unsigned  mismatches;
	int unsigned  cycle_count;
	logic         word_taken;

	// predicted controller state
	logic       ctl_mode;
	logic [4:0] ctl_seconds;
	logic [7:0] ctl_press_ticks;
	logic [1:0] ctl_phase;
	logic [5:0] ctl_lamps;
	logic [7:0] ctl_limit;

	function automatic void set_lamp(input logic [5:0] mask, input logic on);
		if (on)
			ctl_lamps = ctl_lamps | mask;
		else
			ctl_lamps = ctl_lamps & ~mask;
	endfunction

	// one pass of the mode logic, returns 1 when a crossing pass moved the phase on or left crossing mode
	function automatic bit settle_pass();
		logic odd;
		odd = ctl_seconds[0];
		if (!ctl_mode) begin
			if (ctl_seconds < SEC_GREEN_END) begin
				set_lamp(LAMP_CAR_GREEN, 1'b1);
				set_lamp(LAMP_CAR_YELLOW, 1'b0);
				set_lamp(LAMP_CAR_RED, 1'b0);
				ctl_phase = PH_GREEN;
			end else if (ctl_seconds < SEC_BLINK1_END ||
					(ctl_seconds >= SEC_RED_END && ctl_seconds < SEC_BLINK2_END)) begin
				set_lamp(LAMP_CAR_GREEN, 1'b0);
				set_lamp(LAMP_CAR_RED, 1'b0);
				set_lamp(LAMP_CAR_YELLOW, odd);
				ctl_phase = PH_YELLOW;
			end else if (ctl_seconds < SEC_RED_END) begin
				set_lamp(LAMP_CAR_YELLOW, 1'b0);
				set_lamp(LAMP_CAR_GREEN, 1'b0);
				set_lamp(LAMP_CAR_RED, 1'b1);
				ctl_phase = PH_RED;
			end
			return 1'b0;
		end
		case (ctl_phase)
			PH_RED: begin
				set_lamp(LAMP_CAR_YELLOW, 1'b0);
				set_lamp(LAMP_WALK_YEL, 1'b0);
				if (ctl_seconds < SEC_PHASE_END) begin
					set_lamp(LAMP_WALK_GREEN, 1'b1);
					set_lamp(LAMP_CAR_RED, 1'b1);
				end else if (ctl_seconds < SEC_CROSS_END) begin
					set_lamp(LAMP_WALK_GREEN, 1'b0);
					set_lamp(LAMP_CAR_RED, 1'b0);
					set_lamp(LAMP_CAR_YELLOW, odd);
					set_lamp(LAMP_WALK_YEL, odd);
				end else begin
					ctl_mode    = 1'b0;
					ctl_seconds = '0;
					ctl_lamps   = '0;
					return 1'b1;
				end
				return 1'b0;
			end
			PH_YELLOW: begin
				set_lamp(LAMP_WALK_RED, 1'b0);
				set_lamp(LAMP_CAR_GREEN, 1'b0);
				if (ctl_seconds < SEC_PHASE_END) begin
					set_lamp(LAMP_CAR_YELLOW, odd);
					set_lamp(LAMP_WALK_YEL, odd);
					return 1'b0;
				end
				ctl_seconds = '0;
				ctl_phase   = PH_RED;
				return 1'b1;
			end
			PH_GREEN: begin
				set_lamp(LAMP_CAR_GREEN, 1'b1);
				if (ctl_seconds < SEC_HOLD_END) begin
					set_lamp(LAMP_WALK_RED, 1'b1);
					return 1'b0;
				end
				ctl_seconds = '0;
				ctl_phase   = PH_YELLOW;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// advance the predicted controller by one word and give its lamps
	function automatic lamp_result_t next_lamps(input req_word_t w);
		lamp_result_t r;
		int           cyc;
		if (w.req_type == REQ_TICK) begin
			cyc             = ctl_mode ? int'(CYCLE_CROSS) : int'(CYCLE_NORMAL);
			ctl_seconds     = 5'((int'(ctl_seconds) + 1) % cyc);
			ctl_press_ticks = ctl_press_ticks + 8'd1;
		end else if (!ctl_mode) begin
			if (w.button_level == LEVEL_DOWN) begin
				ctl_press_ticks = '0;
			end else if (ctl_press_ticks < ctl_limit) begin
				ctl_mode    = 1'b1;
				ctl_seconds = '0;
				ctl_lamps   = '0;
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (!settle_pass())
				break;
		end
		r.car_red       = |(ctl_lamps & LAMP_CAR_RED);
		r.car_yellow    = |(ctl_lamps & LAMP_CAR_YELLOW);
		r.car_green     = |(ctl_lamps & LAMP_CAR_GREEN);
		r.walk_red      = |(ctl_lamps & LAMP_WALK_RED);
		r.walk_yellow   = |(ctl_lamps & LAMP_WALK_YEL);
		r.walk_green    = |(ctl_lamps & LAMP_WALK_GREEN);
		r.crossing_mode = ctl_mode;
		r.car_phase     = ctl_phase;
		r.second_count  = ctl_seconds;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function automatic void push_word(input logic rt, input logic lvl);
		req_word_t w;
		w.req_type     = rt;
		w.button_level = lvl;
		pending_words.push_back(w);
	endfunction

	// word driver and result ready, both at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			res_ch.ready <= 1'b0;
		end else begin
			if (!req_ch.valid || word_taken) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.req_type     <= pending_words[0].req_type;
					req_ch.button_level <= pending_words[0].button_level;
					req_ch.valid        <= 1'b1;
					void'(pending_words.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: check result words, predict accepted request words
	always @(posedge clk) begin
		lamp_result_t act;
		lamp_result_t exp_r;
		req_word_t    w;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			word_taken <= arst_n && req_ch.valid && req_ch.ready;
			if (arst_n && res_ch.valid && res_ch.ready) begin
				act.car_red       = res_ch.car_red;
				act.car_yellow    = res_ch.car_yellow;
				act.car_green     = res_ch.car_green;
				act.walk_red      = res_ch.walk_red;
				act.walk_yellow   = res_ch.walk_yellow;
				act.walk_green    = res_ch.walk_green;
				act.crossing_mode = res_ch.crossing_mode;
				act.car_phase     = res_ch.car_phase;
				act.second_count  = res_ch.second_count;
				if (expected_lamps.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual %p", $time, act);
					mismatches++;
				end else begin
					exp_r = expected_lamps.pop_front();
					check_field("car_red", exp_r.car_red, act.car_red);
					check_field("car_yellow", exp_r.car_yellow, act.car_yellow);
					check_field("car_green", exp_r.car_green, act.car_green);
					check_field("walk_red", exp_r.walk_red, act.walk_red);
					check_field("walk_yellow", exp_r.walk_yellow, act.walk_yellow);
					check_field("walk_green", exp_r.walk_green, act.walk_green);
					check_field("crossing_mode", exp_r.crossing_mode, act.crossing_mode);
					check_field("car_phase", exp_r.car_phase, act.car_phase);
					check_field("second_count", exp_r.second_count, act.second_count);
				end
			end
			if (arst_n && req_ch.valid && req_ch.ready) begin
				w.req_type     = req_ch.req_type;
				w.button_level = req_ch.button_level;
				expected_lamps.push_back(next_lamps(w));
			end
		end
	end

	// wait until every word is in and every result is out
	task automatic wait_idle();
		while (pending_words.size() > 0 || req_ch.valid || expected_lamps.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write of the short press limit, then read it back
	task automatic write_limit(input logic [7:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_SHORT_PRESS_LIMIT, 2'b00};
		pwdata  <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		ctl_limit = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("short_press_limit", value, prdata[7:0]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stimulus
	initial begin
		int unsigned seg_limit;
		int unsigned start_cnt;
		int unsigned k;
		int unsigned r;
		ctl_mode            = 1'b0;
		ctl_seconds         = '0;
		ctl_press_ticks     = '0;
		ctl_phase           = PH_GREEN;
		ctl_lamps           = '0;
		ctl_limit           = SHORT_PRESS_LIMIT_RST;
		mismatches          = 0;
		cycle_count         = 0;
		word_taken          = 1'b0;
		send_idle_pct       = 30;
		recv_idle_pct       = 54;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_TICK;
		req_ch.button_level = LEVEL_UP;
		res_ch.ready        = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: release with no press, buttons ignored while crossing,
		// the whole sequence from green, a repeated press and a long press
		push_word(REQ_BUTTON, LEVEL_UP);
		push_word(REQ_BUTTON, LEVEL_DOWN);
		push_word(REQ_BUTTON, LEVEL_UP);
		for (int i = 0; i < 17; i++)
			push_word(REQ_TICK, i[0]);
		push_word(REQ_BUTTON, LEVEL_DOWN);
		push_word(REQ_BUTTON, LEVEL_DOWN);
		for (int i = 0; i < 3; i++)
			push_word(REQ_TICK, LEVEL_DOWN);
		push_word(REQ_BUTTON, LEVEL_UP);
		wait_idle();

		// random segments, one limit each, idling pattern per pair
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: seg_limit = 1;
				1: seg_limit = 255;
				2: seg_limit = $urandom_range(4, 12);
				3: seg_limit = 2;
				4: seg_limit = $urandom_range(1, 255);
				default: seg_limit = SHORT_PRESS_LIMIT_RST;
			endcase
			if (seg == 2) begin
				send_idle_pct = 54;
				recv_idle_pct = 30;
			end else if (seg == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_limit(8'(seg_limit));
			// long press so that the tick count may wrap round
			if (seg == 1) begin
				push_word(REQ_BUTTON, LEVEL_DOWN);
				k = $urandom_range(250, 270);
				for (int i = 0; i < k; i++)
					push_word(REQ_TICK, 1'($urandom));
				push_word(REQ_BUTTON, LEVEL_UP);
			end
			start_cnt = pending_words.size();
			while (pending_words.size() - start_cnt < SEG_WORDS) begin
				r = $urandom_range(99);
				if (r < 60) begin
					// press, a few ticks, release, then run through the crossing
					push_word(REQ_BUTTON, LEVEL_DOWN);
					k = $urandom_range(0, (seg_limit > 6) ? 6 : seg_limit + 1);
					for (int i = 0; i < k; i++)
						push_word(REQ_TICK, 1'($urandom));
					push_word(REQ_BUTTON, LEVEL_UP);
					k = $urandom_range(12, 28);
					for (int i = 0; i < k; i++) begin
						if ($urandom_range(9) == 0)
							push_word(REQ_BUTTON, 1'($urandom));
						else
							push_word(REQ_TICK, 1'($urandom));
					end
				end else if (r < 85) begin
					push_word(1'($urandom), 1'($urandom));
				end else begin
					k = $urandom_range(1, 20);
					for (int i = 0; i < k; i++)
						push_word(REQ_TICK, 1'($urandom));
				end
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
